// ===== src/pldc_pkg.sv =====
// shared types and constants for the piecewise linear damage curve
package pldc_pkg;

  // field widths
  localparam int X_W        = 24;
  localparam int BRK_W      = 17;
  localparam int LVL_W      = 17;
  localparam int SLOPE_W    = 32;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // default fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // curve modes
  localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BILINEAR  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRILINEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BREAK_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BREAK_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_BREAK_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_BREAK_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_LEVEL = 3'd5;

  // register reset values
  localparam logic [MODE_W-1:0] RST_CURVE_MODE     = MODE_NONE;
  localparam logic [BRK_W-1:0]  RST_FIRST_BREAK_X  = 17'd32768;
  localparam logic [BRK_W-1:0]  RST_FIRST_BREAK_Y  = 17'd32768;
  localparam logic [BRK_W-1:0]  RST_SECOND_BREAK_X = 17'd49152;
  localparam logic [BRK_W-1:0]  RST_SECOND_BREAK_Y = 17'd49152;
  localparam logic [BRK_W-1:0]  RST_RESIDUAL_LEVEL = 17'd65536;

  // saturation bounds
  localparam logic [SLOPE_W-1:0] SLOPE_MAX = 32'h7FFF_FFFF;
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = 32'h8000_0000;
  localparam logic [LVL_W-1:0]   LEVEL_MAX = 17'h1_FFFF;

  // data that rides alongside the divider chain
  typedef struct packed {
    logic [BRK_W-1:0] ya;
    logic             dy_neg;
  } side_t;

endpackage

// ===== src/pldc_front.sv =====
// segment selection and numerator forming ahead of the divider chain
module pldc_front #(
  parameter int FRAC_BITS = pldc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic signed [pldc_pkg::X_W-1:0]      damage_var,
  input  logic [pldc_pkg::MODE_W-1:0]          curve_mode,
  input  logic [pldc_pkg::BRK_W-1:0]           first_break_x,
  input  logic [pldc_pkg::BRK_W-1:0]           first_break_y,
  input  logic [pldc_pkg::BRK_W-1:0]           second_break_x,
  input  logic [pldc_pkg::BRK_W-1:0]           second_break_y,
  input  logic [pldc_pkg::BRK_W-1:0]           residual_level,
  output logic                                 num_valid,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0]       num_l,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0]       num_s,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                - 1:0]                         dx,
  output pldc_pkg::side_t                      side
);
  import pldc_pkg::*;

  localparam int DX_W  = (FRAC_BITS + 1 > BRK_W) ? FRAC_BITS + 1 : BRK_W;
  localparam int NUM_W = DX_W + BRK_W;
  localparam int CMP_W = (FRAC_BITS + 2 > X_W + 1) ? FRAC_BITS + 2 : X_W + 1;

  logic signed [CMP_W-1:0] xs;
  logic signed [CMP_W-1:0] fbx_c;
  logic signed [CMP_W-1:0] sbx_c;
  logic signed [CMP_W-1:0] one_c;
  logic signed [CMP_W-1:0] xoff_c;
  logic                    le_zero;
  logic                    le_fbx;
  logic                    le_sbx;
  logic                    le_one;
  logic                    active;
  logic                    byp;
  logic [DX_W-1:0]         one_dx;
  logic [DX_W-1:0]         xa;
  logic [DX_W-1:0]         xb;
  logic [BRK_W-1:0]        ya;
  logic [BRK_W-1:0]        yb;
  logic [BRK_W:0]          dy;
  logic [BRK_W:0]          dy_abs;

  // stage a registers
  logic                    a_valid;
  logic [BRK_W-1:0]        a_ya;
  logic                    a_dy_neg;
  logic [BRK_W-1:0]        a_dy_mag;
  logic [DX_W-1:0]         a_dx;
  logic [DX_W-1:0]         a_xoff;
  logic [NUM_W-1:0]        prod;

  // operands sign or zero extended to a common compare width
  assign xs     = {{(CMP_W - X_W){damage_var[X_W-1]}}, damage_var};
  assign fbx_c  = {{(CMP_W - BRK_W){1'b0}}, first_break_x};
  assign sbx_c  = {{(CMP_W - BRK_W){1'b0}}, second_break_x};
  assign one_c  = CMP_W'(1) << FRAC_BITS;
  assign one_dx = DX_W'(1) << FRAC_BITS;

  assign le_zero = damage_var[X_W-1] || (damage_var == '0);
  assign le_fbx  = xs <= fbx_c;
  assign le_sbx  = xs <= sbx_c;
  assign le_one  = xs <= one_c;
  assign active  = (curve_mode == MODE_BILINEAR) || (curve_mode == MODE_TRILINEAR);

  // pick the segment end points, flat cases bypass the slope
  always_comb begin
    byp = 1'b1;
    xa  = '0;
    xb  = '0;
    ya  = '0;
    yb  = '0;
    if (active && !le_zero) begin
      if (le_fbx) begin
        byp = 1'b0;
        xb  = DX_W'(first_break_x);
        yb  = first_break_y;
      end else if ((curve_mode == MODE_TRILINEAR) && le_sbx) begin
        byp = 1'b0;
        xa  = DX_W'(first_break_x);
        ya  = first_break_y;
        xb  = DX_W'(second_break_x);
        yb  = second_break_y;
      end else if (le_one) begin
        byp = 1'b0;
        if (curve_mode == MODE_TRILINEAR) begin
          xa = DX_W'(second_break_x);
          ya = second_break_y;
        end else begin
          xa = DX_W'(first_break_x);
          ya = first_break_y;
        end
        xb = one_dx;
        yb = residual_level;
      end else begin
        ya = residual_level;
        yb = residual_level;
      end
    end
  end

  assign xoff_c = xs - $signed({{(CMP_W - DX_W){1'b0}}, xa});
  assign dy     = {1'b0, yb} - {1'b0, ya};
  assign dy_abs = dy[BRK_W] ? (~dy + 1'b1) : dy;

  // stage a: segment operands
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ya     <= ya;
      a_dy_neg <= dy[BRK_W];
      a_dy_mag <= dy_abs[BRK_W-1:0];
      a_dx     <= byp ? DX_W'(1) : (xb - xa);
      a_xoff   <= byp ? '0 : xoff_c[DX_W-1:0];
    end
  end

  // stage b: level numerator product and slope numerator
  assign prod = a_xoff * a_dy_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_valid <= 1'b0;
    end else if (adv) begin
      num_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_l       <= prod;
      num_s       <= NUM_W'(a_dy_mag) << FRAC_BITS;
      dx          <= a_dx;
      side.ya     <= a_ya;
      side.dy_neg <= a_dy_neg;
    end
  end

endmodule

// ===== src/pldc_div_cell.sv =====
// one restoring division step for the level and slope quotients
module pldc_div_cell #(
  parameter int FRAC_BITS = pldc_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                - 1:0]    in_dx,
  input  logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                - 1:0]    in_rem_l,
  input  logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                - 1:0]    in_rem_s,
  input  logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0] in_nq_l,
  input  logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0] in_nq_s,
  input  pldc_pkg::side_t in_side,
  output logic            out_valid,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                - 1:0]    out_dx,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                - 1:0]    out_rem_l,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                - 1:0]    out_rem_s,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0] out_nq_l,
  output logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0] out_nq_s,
  output pldc_pkg::side_t out_side
);
  import pldc_pkg::*;

  localparam int DX_W  = (FRAC_BITS + 1 > BRK_W) ? FRAC_BITS + 1 : BRK_W;
  localparam int NUM_W = DX_W + BRK_W;

  logic [DX_W:0] t_l;
  logic [DX_W:0] t_s;
  logic [DX_W:0] diff_l;
  logic [DX_W:0] diff_s;
  logic          ge_l;
  logic          ge_s;

  // bring down the next numerator bit and try the subtract
  assign t_l    = {in_rem_l, in_nq_l[NUM_W-1]};
  assign t_s    = {in_rem_s, in_nq_s[NUM_W-1]};
  assign diff_l = t_l - {1'b0, in_dx};
  assign diff_s = t_s - {1'b0, in_dx};
  assign ge_l   = t_l >= {1'b0, in_dx};
  assign ge_s   = t_s >= {1'b0, in_dx};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // quotient bit shifts into the vacated low end of the numerator
  always_ff @(posedge clk) begin
    if (adv) begin
      out_dx    <= in_dx;
      out_side  <= in_side;
      out_rem_l <= ge_l ? diff_l[DX_W-1:0] : t_l[DX_W-1:0];
      out_rem_s <= ge_s ? diff_s[DX_W-1:0] : t_s[DX_W-1:0];
      out_nq_l  <= {in_nq_l[NUM_W-2:0], ge_l};
      out_nq_s  <= {in_nq_s[NUM_W-2:0], ge_s};
    end
  end

endmodule

// ===== src/pldc_back.sv =====
// sign, offset and saturation of the quotients, output register with skid stage
module pldc_back #(
  parameter int FRAC_BITS = pldc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                res_valid,
  input  logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0]      res_nq_l,
  input  logic [((FRAC_BITS + 1 > pldc_pkg::BRK_W) ? FRAC_BITS + 1 : pldc_pkg::BRK_W)
                + pldc_pkg::BRK_W - 1:0]      res_nq_s,
  input  pldc_pkg::side_t                     res_side,
  input  logic                                out_stall,
  output logic                                adv,
  output logic                                out_valid,
  output logic [pldc_pkg::LVL_W-1:0]          level,
  output logic signed [pldc_pkg::SLOPE_W-1:0] slope
);
  import pldc_pkg::*;

  localparam int DX_W  = (FRAC_BITS + 1 > BRK_W) ? FRAC_BITS + 1 : BRK_W;
  localparam int NUM_W = DX_W + BRK_W;

  logic [BRK_W-1:0]          q_l;
  logic signed [BRK_W+1:0]   q_l_signed;
  logic signed [BRK_W+1:0]   lvl_sum;
  logic [LVL_W-1:0]          lvl_c;
  logic [SLOPE_W-1:0]        q_s32;
  logic                      ovf_pos;
  logic                      ovf_neg;
  logic [SLOPE_W-1:0]        slope_c;
  logic                      skid_valid;
  logic [LVL_W-1:0]          skid_level;
  logic [SLOPE_W-1:0]        skid_slope;
  logic                      out_free;

  // level: ya plus the signed quotient, clamped to the level range
  assign q_l        = res_nq_l[BRK_W-1:0];
  assign q_l_signed = res_side.dy_neg ? -$signed({2'b00, q_l}) : $signed({2'b00, q_l});
  assign lvl_sum    = $signed({2'b00, res_side.ya}) + q_l_signed;

  always_comb begin
    if (lvl_sum[BRK_W+1]) begin
      lvl_c = '0;
    end else if (lvl_sum[BRK_W]) begin
      lvl_c = LEVEL_MAX;
    end else begin
      lvl_c = lvl_sum[LVL_W-1:0];
    end
  end

  // slope: saturate the magnitude against the signed 32-bit range
  assign q_s32   = res_nq_s[SLOPE_W-1:0];
  assign ovf_pos = |res_nq_s[NUM_W-1:SLOPE_W-1];
  assign ovf_neg = (|res_nq_s[NUM_W-1:SLOPE_W])
                   || (res_nq_s[SLOPE_W-1] && (|res_nq_s[SLOPE_W-2:0]));

  always_comb begin
    if (res_side.dy_neg) begin
      slope_c = ovf_neg ? SLOPE_MIN : (~q_s32 + 1'b1);
    end else begin
      slope_c = ovf_pos ? SLOPE_MAX : q_s32;
    end
  end

  // the chain moves only while the skid stage is empty
  assign adv      = !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        level <= skid_level;
        slope <= skid_slope;
      end else begin
        level <= lvl_c;
        slope <= slope_c;
      end
    end
    if (!skid_valid) begin
      skid_level <= lvl_c;
      skid_slope <= slope_c;
    end
  end

endmodule

// ===== src/piecewise_linear_damage_curve.sv =====
// Piecewise linear damage curve: level and slope of a damage variable in signed fixed point.
// One item per cycle while in_stall is low: a chain of division cells, one quotient bit each, forms both quotients.
// An output register with a skid stage decouples the two sides.
// Synchronous reset clears all valid flags and loads the register defaults.
module piecewise_linear_damage_curve #(
  parameter int FRAC_BITS = pldc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pldc_pkg::X_W-1:0]       damage_var,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [pldc_pkg::LVL_W-1:0]            level,
  output logic signed [pldc_pkg::SLOPE_W-1:0]   slope,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pldc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pldc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pldc_pkg::*;

  localparam int DX_W  = (FRAC_BITS + 1 > BRK_W) ? FRAC_BITS + 1 : BRK_W;
  localparam int NUM_W = DX_W + BRK_W;

  logic [MODE_W-1:0] curve_mode;
  logic [BRK_W-1:0]  first_break_x;
  logic [BRK_W-1:0]  first_break_y;
  logic [BRK_W-1:0]  second_break_x;
  logic [BRK_W-1:0]  second_break_y;
  logic [BRK_W-1:0]  residual_level;
  logic              adv;

  // divider chain taps
  logic              c_valid [NUM_W+1];
  logic [DX_W-1:0]   c_dx    [NUM_W+1];
  logic [DX_W-1:0]   c_rem_l [NUM_W+1];
  logic [DX_W-1:0]   c_rem_s [NUM_W+1];
  logic [NUM_W-1:0]  c_nq_l  [NUM_W+1];
  logic [NUM_W-1:0]  c_nq_s  [NUM_W+1];
  side_t             c_side  [NUM_W+1];

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode     <= RST_CURVE_MODE;
      first_break_x  <= RST_FIRST_BREAK_X;
      first_break_y  <= RST_FIRST_BREAK_Y;
      second_break_x <= RST_SECOND_BREAK_X;
      second_break_y <= RST_SECOND_BREAK_Y;
      residual_level <= RST_RESIDUAL_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CURVE_MODE:     curve_mode     <= cfg_data[MODE_W-1:0];
        REG_FIRST_BREAK_X:  first_break_x  <= cfg_data[BRK_W-1:0];
        REG_FIRST_BREAK_Y:  first_break_y  <= cfg_data[BRK_W-1:0];
        REG_SECOND_BREAK_X: second_break_x <= cfg_data[BRK_W-1:0];
        REG_SECOND_BREAK_Y: second_break_y <= cfg_data[BRK_W-1:0];
        REG_RESIDUAL_LEVEL: residual_level <= cfg_data[BRK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input transfer whenever the chain moves
  assign in_stall = !adv;

  pldc_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (in_valid),
    .damage_var     (damage_var),
    .curve_mode     (curve_mode),
    .first_break_x  (first_break_x),
    .first_break_y  (first_break_y),
    .second_break_x (second_break_x),
    .second_break_y (second_break_y),
    .residual_level (residual_level),
    .num_valid      (c_valid[0]),
    .num_l          (c_nq_l[0]),
    .num_s          (c_nq_s[0]),
    .dx             (c_dx[0]),
    .side           (c_side[0])
  );

  assign c_rem_l[0] = '0;
  assign c_rem_s[0] = '0;

  // one cell per numerator bit
  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    pldc_div_cell #(
      .FRAC_BITS(FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (c_valid[g]),
      .in_dx     (c_dx[g]),
      .in_rem_l  (c_rem_l[g]),
      .in_rem_s  (c_rem_s[g]),
      .in_nq_l   (c_nq_l[g]),
      .in_nq_s   (c_nq_s[g]),
      .in_side   (c_side[g]),
      .out_valid (c_valid[g+1]),
      .out_dx    (c_dx[g+1]),
      .out_rem_l (c_rem_l[g+1]),
      .out_rem_s (c_rem_s[g+1]),
      .out_nq_l  (c_nq_l[g+1]),
      .out_nq_s  (c_nq_s[g+1]),
      .out_side  (c_side[g+1])
    );
  end

  pldc_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .res_valid (c_valid[NUM_W]),
    .res_nq_l  (c_nq_l[NUM_W]),
    .res_nq_s  (c_nq_s[NUM_W]),
    .res_side  (c_side[NUM_W]),
    .out_stall (out_stall),
    .adv       (adv),
    .out_valid (out_valid),
    .level     (level),
    .slope     (slope)
  );

  // remainders of the last cell are not needed
  logic unused_rem;
  assign unused_rem = ^{c_rem_l[NUM_W], c_rem_s[NUM_W], c_dx[NUM_W]};

endmodule
